// ===== rtl/laplacian_of_gaussian_edge_filter_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the Laplacian-of-Gaussian edge filter
// Two property forms shared by the assertions at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef LAPLACIAN_OF_GAUSSIAN_EDGE_FILTER_ASSERT_SVH
`define LAPLACIAN_OF_GAUSSIAN_EDGE_FILTER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define LOGE_ASSERT_HOLD(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LOGE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/log_edge_pkg.sv =====
// ---------------------------------------------------------------------------
// Laplacian-of-Gaussian edge filter package
// Command and register codes, field widths and the Gaussian weight tables.
// ---------------------------------------------------------------------------
package log_edge_pkg;

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_DRAIN = 1'b1
   } cmd_type;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   localparam int unsigned CSR_INDEX_W        = 1;
   localparam int unsigned CSR_DATA_W         = 13;
   localparam int unsigned FRAME_WIDTH_BITS   = 11;
   localparam int unsigned FRAME_HEIGHT_BITS  = 13;
   localparam int unsigned FRAME_WIDTH_RESET  = 640;
   localparam int unsigned FRAME_HEIGHT_RESET = 480;
   localparam int unsigned FRAME_MIN_SIZE     = 3;
   localparam int unsigned PIXEL_W            = 8;
   localparam int unsigned BLUR_W             = 16;
   localparam int unsigned CLASS_SUM_W        = 11;
   localparam int unsigned NUM_CLASSES        = 6;
   localparam int unsigned Q20_BITS           = 20;

   // Off-centre weights in Q0.20, indexed by distance class.
   localparam int unsigned GAUSS_Q20 [NUM_CLASSES] =
      '{0, 103096, 62531, 23004, 13953, 3113};

   // Distance class of each tap of the 5x5 window.
   localparam logic [2:0] GAUSS_CLASS [5][5] = '{
      '{3'd5, 3'd4, 3'd3, 3'd4, 3'd5},
      '{3'd4, 3'd2, 3'd1, 3'd2, 3'd4},
      '{3'd3, 3'd1, 3'd0, 3'd1, 3'd3},
      '{3'd4, 3'd2, 3'd1, 3'd2, 3'd4},
      '{3'd5, 3'd4, 3'd3, 3'd4, 3'd5}
   };

   // Weight of one class at the given fraction width. The centre weight takes
   // up the remainder so that all 25 weights sum to exactly one.
   function automatic int unsigned gauss_coef(input int unsigned cls,
                                              input int unsigned frac);
      int unsigned sh;
      int unsigned half;
      int unsigned rest;
      int unsigned c;
      int unsigned res;
      sh   = Q20_BITS - frac;
      half = (sh > 0) ? (1 << (sh - 1)) : 0;
      rest = 0;
      res  = 0;
      for (int unsigned j = 1; j < NUM_CLASSES; j++) begin
         c    = (GAUSS_Q20[j] + half) >> sh;
         rest = rest + c * ((j == 4) ? 8 : 4);
         if (j == cls) begin
            res = c;
         end
      end
      if (cls == 0) begin
         res = (1 << frac) - rest;
      end
      return res;
   endfunction

endpackage

// ===== rtl/laplacian_of_gaussian_edge_filter.sv =====
// ---------------------------------------------------------------------------
// Laplacian-of-Gaussian edge filter
// 5x5 Gaussian blur followed by an 8-neighbour 3x3 Laplacian on a raster
// stream of grey pixels, with line stores and sliding windows.
// ---------------------------------------------------------------------------
// The filter takes one transaction per clock on the request channel and gives
// one result transaction per clock as long as the result channel is not
// stalled; a stalled result holds the whole pipeline. Results lag the pixels
// by three rows and three pixels, so after the last pixel of a frame the owed
// results are pulled out by drain transactions, one result each. On frames
// smaller than that lag a drain may first have to step the pipeline through
// positions that give nothing; it then holds off further requests until it
// reaches a step that gives a result, and longer while the result channel
// stalls. Writing frame_width or frame_height restarts the frame; configure
// only while the filter is idle.
// ---------------------------------------------------------------------------
module laplacian_of_gaussian_edge_filter #(
   parameter int unsigned MAX_WIDTH      = 1024,
   parameter int unsigned MAX_HEIGHT     = 4096,
   parameter int unsigned COEF_FRAC_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_cmd,
   input  logic [log_edge_pkg::PIXEL_W-1:0]        req_pixel,
   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [log_edge_pkg::PIXEL_W-1:0]        rsp_edge_value,
   output logic                                    rsp_last_of_frame,
   // register write channel
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [log_edge_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [log_edge_pkg::CSR_DATA_W-1:0]     csr_data
);
   import log_edge_pkg::*;

   localparam int unsigned COL_W    = $clog2(MAX_WIDTH);
   localparam int unsigned WID_W    = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HGT_W    = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned ROW_W    = $clog2(MAX_HEIGHT) + 1;
   localparam int unsigned ACC_W    = COEF_FRAC_BITS + 9;
   localparam int unsigned SH       = COEF_FRAC_BITS - 8;
   localparam int unsigned RND      = (SH > 0) ? (1 << (SH - 1)) : 0;
   localparam int unsigned NSUM_W   = BLUR_W + 3;
   localparam int unsigned DIFF_W   = BLUR_W + 4;
   localparam int unsigned RESET_WIDTH =
      (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;
   localparam int unsigned RESET_HEIGHT =
      (FRAME_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RESET;

   localparam int unsigned COEF [NUM_CLASSES] = '{
      gauss_coef(0, COEF_FRAC_BITS), gauss_coef(1, COEF_FRAC_BITS),
      gauss_coef(2, COEF_FRAC_BITS), gauss_coef(3, COEF_FRAC_BITS),
      gauss_coef(4, COEF_FRAC_BITS), gauss_coef(5, COEF_FRAC_BITS)
   };

   // What every pipeline stage carries about the step it holds: where the
   // blur centre and the Laplacian centre of this step sit in the frame.
   typedef struct packed {
      logic [COL_W-1:0] blur_col;
      logic             blur_interior;
      logic             lap_valid;
      logic             lap_interior;
      logic             lap_last;
   } step_meta_type;

   // ------------------------------------------------------------------
   // Configuration registers and frame position
   // ------------------------------------------------------------------
   logic [WID_W-1:0] width_ff;
   logic [HGT_W-1:0] height_ff;
   logic [COL_W-1:0] col_ff,  col_in;
   logic [ROW_W-1:0] row_ff,  row_in;
   logic             done_ff, done_in;
   logic             drain_busy_ff, drain_busy_in;

   logic             csr_wr;
   logic [31:0]      csr_width_raw, csr_height_raw;
   logic [31:0]      csr_width_sat, csr_height_sat;

   logic             pipe_advance;
   logic             req_acc;
   logic             is_pixel;
   logic             frame_over;
   logic             restart_now;
   logic             step_issue;
   logic             step_is_drain;
   logic [COL_W-1:0] pos_col;
   logic [ROW_W-1:0] pos_row;
   logic [WID_W-1:0] col_ext;
   logic [WID_W-1:0] col_inc;

   // A register write is never refused while the filter is not stepping a
   // drain by itself.
   assign csr_ready = !drain_busy_ff;
   assign csr_wr    = csr_valid && csr_ready;

   always_comb begin
      csr_width_raw  = 32'(csr_data[FRAME_WIDTH_BITS-1:0]);
      csr_height_raw = 32'(csr_data[FRAME_HEIGHT_BITS-1:0]);
      if (csr_width_raw < FRAME_MIN_SIZE) begin
         csr_width_sat = FRAME_MIN_SIZE;
      end else if (csr_width_raw > MAX_WIDTH) begin
         csr_width_sat = MAX_WIDTH;
      end else begin
         csr_width_sat = csr_width_raw;
      end
      if (csr_height_raw < FRAME_MIN_SIZE) begin
         csr_height_sat = FRAME_MIN_SIZE;
      end else if (csr_height_raw > MAX_HEIGHT) begin
         csr_height_sat = MAX_HEIGHT;
      end else begin
         csr_height_sat = csr_height_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WID_W'(RESET_WIDTH);
         height_ff <= HGT_W'(RESET_HEIGHT);
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  width_ff  <= WID_W'(csr_width_sat);
            REG_FRAME_HEIGHT: height_ff <= HGT_W'(csr_height_sat);
            default: ;
         endcase
      end
   end

   // The whole pipeline moves together; only a result that is waiting on a
   // stalled result channel holds it.
   logic rsp_valid_ff;
   assign pipe_advance = !(rsp_valid_ff && rsp_stall);
   assign req_stall    = !pipe_advance || drain_busy_ff;
   assign req_acc      = req_valid && !req_stall;
   assign is_pixel     = (req_cmd == CMD_PIXEL);

   // Once the position has passed the last row the frame has been fully
   // received: a pixel then starts a new frame, and a drain steps the
   // pipeline on as long as the frame still owes results.
   assign frame_over  = (row_ff >= ROW_W'(height_ff));
   assign restart_now = req_acc && is_pixel && frame_over;

   always_comb begin
      if (drain_busy_ff) begin
         step_issue = pipe_advance;
      end else begin
         step_issue = req_acc && (is_pixel || (frame_over && !done_ff));
      end
      step_is_drain = drain_busy_ff || !is_pixel;
      pos_col       = restart_now ? '0 : col_ff;
      pos_row       = restart_now ? '0 : row_ff;
   end

   // ------------------------------------------------------------------
   // Blur and Laplacian centres for the step being issued. The blur centre
   // trails the newest position by two rows and two pixels, the Laplacian
   // centre by three rows and three pixels.
   // ------------------------------------------------------------------
   logic signed [ROW_W:0] hgt_s;
   logic signed [ROW_W:0] row_s;
   logic                  bcol_wrap, lcol_wrap;
   logic [WID_W-1:0]      bcol_wide, lcol_wide;
   logic signed [ROW_W:0] brow, lrow;
   step_meta_type         issue_meta;

   always_comb begin
      hgt_s     = (ROW_W + 1)'(height_ff);
      row_s     = $signed({1'b0, pos_row});
      col_ext   = WID_W'(pos_col);
      bcol_wrap = (col_ext < WID_W'(2));
      lcol_wrap = (col_ext < WID_W'(3));
      bcol_wide = bcol_wrap ? (col_ext + width_ff - WID_W'(2)) : (col_ext - WID_W'(2));
      lcol_wide = lcol_wrap ? (col_ext + width_ff - WID_W'(3)) : (col_ext - WID_W'(3));
      brow      = row_s - (bcol_wrap ? (ROW_W + 1)'(3) : (ROW_W + 1)'(2));
      lrow      = row_s - (lcol_wrap ? (ROW_W + 1)'(4) : (ROW_W + 1)'(3));

      issue_meta.blur_col      = COL_W'(bcol_wide);
      issue_meta.blur_interior = (brow >= 2) && ((brow + 2) < hgt_s)
                                 && (bcol_wide >= WID_W'(2))
                                 && ((bcol_wide + WID_W'(2)) < width_ff);
      issue_meta.lap_valid     = (lrow >= 0) && (lrow < hgt_s);
      issue_meta.lap_interior  = (lrow >= 1) && ((lrow + 1) < hgt_s)
                                 && (lcol_wide >= WID_W'(1))
                                 && ((lcol_wide + WID_W'(1)) < width_ff);
      issue_meta.lap_last      = (lrow == (hgt_s - 1))
                                 && (lcol_wide == (width_ff - WID_W'(1)));
   end

   // Position, drain and end-of-frame bookkeeping.
   always_comb begin
      col_inc       = col_ext + WID_W'(1);
      col_in        = col_ff;
      row_in        = row_ff;
      done_in       = done_ff;
      drain_busy_in = drain_busy_ff;
      if (csr_wr) begin
         col_in        = '0;
         row_in        = '0;
         done_in       = 1'b0;
         drain_busy_in = 1'b0;
      end else if (step_issue) begin
         if (col_inc == width_ff) begin
            col_in = '0;
            row_in = pos_row + ROW_W'(1);
         end else begin
            col_in = COL_W'(col_inc);
            row_in = pos_row;
         end
         // A drain keeps stepping until it reaches a step that gives a result.
         drain_busy_in = step_is_drain && !issue_meta.lap_valid;
         if (issue_meta.lap_valid && issue_meta.lap_last) begin
            done_in = 1'b1;
         end else if (restart_now) begin
            done_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         done_ff       <= 1'b0;
         drain_busy_ff <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         done_ff       <= done_in;
         drain_busy_ff <= drain_busy_in;
      end
   end

   // ------------------------------------------------------------------
   // Pipeline valid bits and step descriptions
   // ------------------------------------------------------------------
   logic [7:1]    stage_v_ff;
   step_meta_type meta_ff [1:7];

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= '0;
      end else if (pipe_advance) begin
         stage_v_ff <= {stage_v_ff[6:1], step_issue};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         meta_ff[1] <= issue_meta;
         for (int k = 2; k <= 7; k++) begin
            meta_ff[k] <= meta_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: raw line store. Each entry holds the four previous rows of one
   // column, newest row in the low byte; the read is issued with the step
   // and the shifted column is written back one stage later.
   // ------------------------------------------------------------------
   logic [4*PIXEL_W-1:0] raw_line_store [MAX_WIDTH];
   logic [4*PIXEL_W-1:0] raw_rd_ff;
   logic [COL_W-1:0]     s1_col_ff;
   logic [PIXEL_W-1:0]   s1_pixel_ff;
   logic [PIXEL_W-1:0]   raw_col_vec [5];
   logic [PIXEL_W-1:0]   raw_win_ff [5][5];

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         raw_rd_ff   <= raw_line_store[pos_col];
         s1_col_ff   <= pos_col;
         s1_pixel_ff <= req_pixel;
         if (stage_v_ff[1]) begin
            raw_line_store[s1_col_ff] <= {raw_rd_ff[3*PIXEL_W-1:0], s1_pixel_ff};
         end
      end
   end

   always_comb begin
      raw_col_vec[0] = s1_pixel_ff;
      for (int r = 1; r < 5; r++) begin
         raw_col_vec[r] = raw_rd_ff[(r-1)*PIXEL_W +: PIXEL_W];
      end
   end

   // Stage 2: the 5x5 raw window, newest column first.
   always_ff @(posedge clock) begin
      if (pipe_advance && stage_v_ff[1]) begin
         for (int r = 0; r < 5; r++) begin
            raw_win_ff[0][r] <= raw_col_vec[r];
         end
         for (int c = 1; c < 5; c++) begin
            for (int r = 0; r < 5; r++) begin
               raw_win_ff[c][r] <= raw_win_ff[c-1][r];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stages 3 to 5: Gaussian blur. The window is symmetric, so taps of equal
   // distance are summed first and each class takes one constant multiply.
   // ------------------------------------------------------------------
   logic [CLASS_SUM_W-1:0] class_sum [NUM_CLASSES];
   logic [CLASS_SUM_W-1:0] class_sum_ff [NUM_CLASSES];
   logic [PIXEL_W-1:0]     s3_centre_ff, s4_centre_ff;
   logic [ACC_W-1:0]       prod_ff [NUM_CLASSES];
   logic [ACC_W-1:0]       blur_acc;
   logic [ACC_W-1:0]       blur_rounded;
   logic [BLUR_W-1:0]      blur_value;
   logic [BLUR_W-1:0]      blur_ff;

   always_comb begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
         class_sum[k] = '0;
      end
      for (int c = 0; c < 5; c++) begin
         for (int r = 0; r < 5; r++) begin
            class_sum[GAUSS_CLASS[c][r]] = class_sum[GAUSS_CLASS[c][r]]
                                           + CLASS_SUM_W'(raw_win_ff[c][r]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         class_sum_ff <= class_sum;
         s3_centre_ff <= raw_win_ff[2][2];
         for (int k = 0; k < NUM_CLASSES; k++) begin
            prod_ff[k] <= ACC_W'(class_sum_ff[k]) * ACC_W'(COEF[k]);
         end
         s4_centre_ff <= s3_centre_ff;
         blur_ff      <= blur_value;
      end
   end

   always_comb begin
      blur_acc = '0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
         blur_acc = blur_acc + prod_ff[k];
      end
      blur_rounded = (blur_acc + ACC_W'(RND)) >> SH;
      if (!meta_ff[4].blur_interior) begin
         // The two-pixel border keeps its raw value.
         blur_value = {s4_centre_ff, 8'h00};
      end else if (blur_rounded > ACC_W'({BLUR_W{1'b1}})) begin
         blur_value = {BLUR_W{1'b1}};
      end else begin
         blur_value = BLUR_W'(blur_rounded);
      end
   end

   // ------------------------------------------------------------------
   // Stages 5 and 6: blur line store (two previous rows per column) and the
   // 3x3 blurred window.
   // ------------------------------------------------------------------
   logic [2*BLUR_W-1:0] blur_line_store [MAX_WIDTH];
   logic [2*BLUR_W-1:0] blur_rd_ff;
   logic [COL_W-1:0]    s5_col_ff;
   logic [BLUR_W-1:0]   blur_col_vec [3];
   logic [BLUR_W-1:0]   blur_win_ff [3][3];

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         blur_rd_ff <= blur_line_store[meta_ff[4].blur_col];
         s5_col_ff  <= meta_ff[4].blur_col;
         if (stage_v_ff[5]) begin
            blur_line_store[s5_col_ff] <= {blur_rd_ff[BLUR_W-1:0], blur_ff};
         end
      end
   end

   always_comb begin
      blur_col_vec[0] = blur_ff;
      blur_col_vec[1] = blur_rd_ff[BLUR_W-1:0];
      blur_col_vec[2] = blur_rd_ff[2*BLUR_W-1:BLUR_W];
   end

   always_ff @(posedge clock) begin
      if (pipe_advance && stage_v_ff[5]) begin
         for (int r = 0; r < 3; r++) begin
            blur_win_ff[0][r] <= blur_col_vec[r];
         end
         for (int c = 1; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               blur_win_ff[c][r] <= blur_win_ff[c-1][r];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stages 7 and 8: Laplacian (eight times the centre less the eight
   // neighbours), clamped to 0..255 after dropping the fraction.
   // ------------------------------------------------------------------
   logic [NSUM_W-1:0]        neigh_sum;
   logic [NSUM_W-1:0]        neigh_sum_ff;
   logic [BLUR_W-1:0]        lap_centre_ff;
   logic signed [DIFF_W-1:0] lap_diff;
   logic [PIXEL_W-1:0]       edge_value;
   logic [PIXEL_W-1:0]       rsp_edge_ff;
   logic                     rsp_last_ff;

   always_comb begin
      neigh_sum = '0;
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            if (!(c == 1 && r == 1)) begin
               neigh_sum = neigh_sum + NSUM_W'(blur_win_ff[c][r]);
            end
         end
      end
   end

   always_comb begin
      lap_diff = $signed({1'b0, lap_centre_ff, 3'b000}) - $signed({1'b0, neigh_sum_ff});
      if (!meta_ff[7].lap_interior || lap_diff < 0) begin
         // The outer one-pixel ring and negative responses give zero.
         edge_value = '0;
      end else if (lap_diff[DIFF_W-1:8] > (DIFF_W - 8)'(255)) begin
         edge_value = 8'hFF;
      end else begin
         edge_value = lap_diff[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         neigh_sum_ff  <= neigh_sum;
         lap_centre_ff <= blur_win_ff[1][1];
         rsp_edge_ff   <= edge_value;
         rsp_last_ff   <= meta_ff[7].lap_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_advance) begin
         rsp_valid_ff <= stage_v_ff[7] && meta_ff[7].lap_valid;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_edge_value    = rsp_edge_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
`include "laplacian_of_gaussian_edge_filter_assert.svh"

   `LOGE_ASSERT_HOLD(a_no_request_while_draining, clock, reset, drain_busy_ff, req_stall, "request taken while a drain steps the pipeline")
   `LOGE_ASSERT_NEXT(a_position_frozen_on_stall, clock, reset, !pipe_advance && !csr_wr, $stable(col_ff) && $stable(row_ff), "frame position moved while the pipeline was held")
   `LOGE_ASSERT_HOLD(a_column_inside_row, clock, reset, 1'b1, WID_W'(col_ff) < width_ff, "column position beyond the row width")

endmodule

// ===== sim/log_edge_checker.sv =====
// ---------------------------------------------------------------------------
// Laplacian-of-Gaussian edge filter checker
// Watches the request, result and register channels, keeps its own model of
// the line stores and frame position, and compares every result transaction
// with the oldest predicted one.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module log_edge_checker #(
   parameter int unsigned MAX_WIDTH      = 1024,
   parameter int unsigned MAX_HEIGHT     = 4096,
   parameter int unsigned COEF_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic                                 req_cmd,
   input  logic [log_edge_pkg::PIXEL_W-1:0]     req_pixel,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [log_edge_pkg::PIXEL_W-1:0]     rsp_edge_value,
   input  logic                                 rsp_last_of_frame,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [log_edge_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [log_edge_pkg::CSR_DATA_W-1:0]  csr_data,
   output int unsigned                          outstanding,
   output int unsigned                          mismatches
);
   import log_edge_pkg::*;

   typedef struct packed {
      logic [7:0] edge_value;
      logic       last_of_frame;
   } edge_result_type;

   localparam int unsigned TAP_Q20 [6] = '{0, 103096, 62531, 23004, 13953, 3113};

   edge_result_type expected_edges [$];
   logic [7:0]   raw_rows  [5][MAX_WIDTH];
   logic [15:0]  blur_rows [3][MAX_WIDTH];
   int unsigned  tap_weight [6];
   int unsigned  width_px, height_px, col_pos, row_pos, owed;
   int unsigned  error_count;

   function automatic int unsigned tap_class(input int unsigned dy, input int unsigned dx);
      int unsigned ady, adx;
      ady = (dy > 2) ? dy - 2 : 2 - dy;
      adx = (dx > 2) ? dx - 2 : 2 - dx;
      case (ady * ady + adx * adx)
         0: return 0;
         1: return 1;
         2: return 2;
         4: return 3;
         5: return 4;
         default: return 5;
      endcase
   endfunction

   function automatic void build_weights();
      int unsigned sh, half, rest;
      sh   = 20 - COEF_FRAC_BITS;
      half = (sh > 0) ? (1 << (sh - 1)) : 0;
      rest = 0;
      for (int unsigned k = 1; k < 6; k++) begin
         tap_weight[k] = (TAP_Q20[k] + half) >> sh;
         rest += tap_weight[k] * ((k == 4) ? 8 : 4);
      end
      tap_weight[0] = (1 << COEF_FRAC_BITS) - rest;
   endfunction

   function automatic void restart_frame();
      col_pos = 0;
      row_pos = 0;
      owed    = width_px * height_px;
   endfunction

   function automatic void blur_at(input int unsigned p);
      int unsigned br, bc, acc, v, s;
      br = p / width_px;
      bc = p % width_px;
      s  = COEF_FRAC_BITS - 8;
      if (br >= 2 && br + 2 < height_px && bc >= 2 && bc + 2 < width_px) begin
         acc = 0;
         for (int unsigned dy = 0; dy < 5; dy++)
            for (int unsigned dx = 0; dx < 5; dx++)
               acc += tap_weight[tap_class(dy, dx)] * raw_rows[(br + dy - 2) % 5][bc + dx - 2];
         if (s > 0)
            acc = (acc + (1 << (s - 1))) >> s;
         v = (acc > 32'hFFFF) ? 32'hFFFF : acc;
      end else begin
         v = 32'(raw_rows[br % 5][bc]) << 8;
      end
      blur_rows[br % 3][bc] = v[15:0];
   endfunction

   function automatic logic [7:0] laplace_at(input int unsigned q);
      int unsigned lr, lc;
      int          sum, b;
      lr = q / width_px;
      lc = q % width_px;
      if (lr < 1 || lr + 1 >= height_px || lc < 1 || lc + 1 >= width_px)
         return 8'd0;
      sum = 0;
      for (int unsigned dy = 0; dy < 3; dy++)
         for (int unsigned dx = 0; dx < 3; dx++) begin
            b = blur_rows[(lr + dy - 1) % 3][lc + dx - 1];
            sum += (dy == 1 && dx == 1) ? 8 * b : -b;
         end
      if (sum < 0)
         return 8'd0;
      sum = sum >>> 8;
      return (sum > 255) ? 8'd255 : sum[7:0];
   endfunction

   // One position of the pipeline; gives a result once the lag has passed.
   function automatic bit step_pipeline(input bit is_pixel, input logic [7:0] p,
                                        output edge_result_type r);
      int unsigned total, pos, lag2, lag3, q;
      bit          made;
      total = width_px * height_px;
      pos   = row_pos * width_px + col_pos;
      lag2  = 2 * width_px + 2;
      lag3  = 3 * width_px + 3;
      made  = 1'b0;
      r     = '0;
      if (is_pixel)
         raw_rows[row_pos % 5][col_pos] = p;
      if (pos >= lag2 && pos - lag2 < total)
         blur_at(pos - lag2);
      if (pos >= lag3 && pos - lag3 < total && owed > 0) begin
         q               = pos - lag3;
         r.edge_value    = laplace_at(q);
         r.last_of_frame = (q == total - 1);
         owed--;
         made = 1'b1;
      end
      col_pos++;
      if (col_pos >= width_px) begin
         col_pos = 0;
         row_pos++;
      end
      return made;
   endfunction

   function automatic bit process_request(input cmd_type c, input logic [7:0] p,
                                          output edge_result_type r);
      int unsigned total, pos;
      r     = '0;
      total = width_px * height_px;
      pos   = row_pos * width_px + col_pos;
      if (c == CMD_PIXEL) begin
         // A pixel past the end of the frame opens a new one.
         if (pos >= total)
            restart_frame();
         return step_pipeline(1'b1, p, r);
      end
      if (pos < total || owed == 0)
         return 1'b0;
      // Small frames may need several empty steps before a drain yields.
      for (int unsigned g = 0; g < 3 * width_px + 4; g++)
         if (step_pipeline(1'b0, 8'd0, r))
            return 1'b1;
      return 1'b0;
   endfunction

   function automatic void apply_register(input reg_index_type idx, input logic [12:0] data);
      int unsigned v;
      if (idx == REG_FRAME_WIDTH) begin
         v        = data[10:0];
         width_px = (v < 3) ? 3 : ((v > MAX_WIDTH) ? MAX_WIDTH : v);
      end else begin
         v         = data;
         height_px = (v < 3) ? 3 : ((v > MAX_HEIGHT) ? MAX_HEIGHT : v);
      end
      restart_frame();
   endfunction

   initial begin
      error_count = 0;
      build_weights();
   end

   always @(posedge clock) begin
      edge_result_type want, fresh;
      if (reset) begin
         expected_edges.delete();
         for (int i = 0; i < 5; i++)
            for (int j = 0; j < MAX_WIDTH; j++)
               raw_rows[i][j] = '0;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < MAX_WIDTH; j++)
               blur_rows[i][j] = '0;
         width_px  = FRAME_WIDTH_RESET;
         height_px = FRAME_HEIGHT_RESET;
         restart_frame();
         outstanding <= 0;
         mismatches  <= error_count;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_edges.size() == 0) begin
               $error("edge_value: unexpected transaction, expected none, actual %0d",
                      rsp_edge_value);
               error_count++;
            end else begin
               want = expected_edges.pop_front();
               if (rsp_edge_value !== want.edge_value) begin
                  $error("edge_value: expected %0d, actual %0d", want.edge_value,
                         rsp_edge_value);
                  error_count++;
               end
               if (rsp_last_of_frame !== want.last_of_frame) begin
                  $error("last_of_frame: expected %0d, actual %0d", want.last_of_frame,
                         rsp_last_of_frame);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready)
            apply_register(reg_index_type'(csr_index), csr_data);
         if (req_valid && !req_stall)
            if (process_request(cmd_type'(req_cmd), req_pixel, fresh))
               expected_edges.push_back(fresh);
         outstanding <= expected_edges.size();
         mismatches  <= error_count;
      end
   end

endmodule

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// Laplacian-of-Gaussian edge filter testbench
// Drives pixel and drain transactions over a range of frame sizes, with
// random gaps and result stalls, and reports the verdict of the checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import log_edge_pkg::*;

   // Longest quiet spell that a correct run can show is a drain stepping
   // through a full-width lag, or the settling pause before a register write.
   localparam int unsigned WATCHDOG_LIMIT = 20000;
   localparam int unsigned TARGET_PIXELS  = 1450;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_cmd   = CMD_PIXEL;
   logic [PIXEL_W-1:0]     req_pixel = '0;
   logic                   rsp_stall = 1'b0;
   logic                   csr_valid = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;
   logic                   req_stall, rsp_valid, rsp_last_of_frame, csr_ready;
   logic [PIXEL_W-1:0]     rsp_edge_value;

   int unsigned outstanding, mismatches;
   int unsigned idle_cycles = 0;
   int unsigned stall_left  = 0;
   int unsigned frame_cols  = FRAME_WIDTH_RESET;
   int unsigned frame_rows  = FRAME_HEIGHT_RESET;
   int unsigned pixels_sent = 0;
   bit          steady_sender = 1'b0;

   always #5 clock = ~clock;

   laplacian_of_gaussian_edge_filter u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_pixel         (req_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_edge_value    (rsp_edge_value),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   log_edge_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_pixel         (req_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_edge_value    (rsp_edge_value),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .outstanding       (outstanding),
      .mismatches        (mismatches)
   );

   // The result side alternates between free stretches and stalls, and now and
   // then either of them is much longer than usual.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_stall) begin
         rsp_stall  <= 1'b0;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                   : $urandom_range(0, 12);
      end else begin
         rsp_stall  <= 1'b1;
         stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(0, 2);
      end
   end

   // The watchdog ends the run when no channel has moved a transaction for
   // too long, which is how a lost result or a hung handshake shows up.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Gaps on the request side: mostly none, often short, occasionally long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // Pixel content styles: plain noise, hard black and white edges that drive
   // the clamp to 255, a nearly flat field, and sparse bright spots.
   function automatic logic [7:0] make_pixel(input int unsigned style);
      case (style)
         0: return 8'($urandom_range(0, 255));
         1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
         2: return 8'(120 + $urandom_range(0, 15));
         default: return ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 40));
      endcase
   endfunction

   // Presents one request transaction and holds it until it is taken. Valid
   // stays high into the next call when no gap is drawn.
   task automatic send_req(input cmd_type c, input logic [7:0] p);
      int unsigned gap;
      gap = steady_sender ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= c;
      req_pixel <= p;
      do @(posedge clock); while (req_stall);
   endtask

   // Waits for every predicted result, then lets a full drain step of the
   // current width go by so that the filter is surely idle.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (3 * frame_cols + 16) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [12:0] value);
      int unsigned v;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_FRAME_WIDTH) begin
         v          = value[10:0];
         frame_cols = (v < 3) ? 3 : ((v > 1024) ? 1024 : v);
      end else begin
         v          = value;
         frame_rows = (v < 3) ? 3 : ((v > 4096) ? 4096 : v);
      end
   endtask

   // Sends pixels of one frame, with the odd drain thrown in mid-frame (the
   // filter must ignore those), followed by the given number of drains.
   task automatic run_frame(input int unsigned count, input int unsigned drains,
                            input int unsigned style);
      for (int unsigned i = 0; i < count; i++) begin
         if (i > 0 && $urandom_range(0, 39) == 0)
            send_req(CMD_DRAIN, 8'($urandom_range(0, 255)));
         send_req(CMD_PIXEL, make_pixel(style));
         pixels_sent++;
      end
      for (int unsigned d = 0; d < drains; d++) begin
         send_req(CMD_DRAIN, 8'($urandom_range(0, 255)));
         pixels_sent++;
      end
   endtask

   function automatic logic [12:0] width_code();
      int unsigned r;
      logic [10:0] w;
      r = $urandom_range(0, 99);
      if (r < 70)
         w = 11'($urandom_range(3, 10));
      else if (r < 88)
         w = 11'($urandom_range(11, 32));
      else if (r < 94)
         w = 11'($urandom_range(0, 2));
      else
         w = 11'($urandom_range(0, 2047));
      // The top bits lie outside the width field and must be ignored.
      return {2'($urandom_range(0, 3)), w};
   endfunction

   function automatic logic [12:0] height_code();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 13'($urandom_range(3, 10));
      if (r < 88)
         return 13'($urandom_range(11, 24));
      if (r < 94)
         return 13'($urandom_range(0, 2));
      return 13'($urandom_range(0, 8191));
   endfunction

   initial begin
      int unsigned total, owed, r;
      bit          must_configure;
      logic [7:0]  corner_pixels [6];

      corner_pixels = '{8'd0, 8'd255, 8'h55, 8'hAA, 8'd1, 8'd128};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A few pixels at the reset frame size, too few for any
      // result, with a drain mid-frame that must be ignored.
      steady_sender = 1'b1;
      for (int i = 0; i < 6; i++) begin
         send_req(CMD_PIXEL, corner_pixels[i]);
         if (i == 1)
            send_req(CMD_DRAIN, 8'hFF);
      end
      settle();

      // Register values below the minimum give the smallest 3x3 frame, whose
      // lag is longer than the frame itself: every result needs a drain that
      // steps the pipeline, and one extra drain with nothing owed is ignored.
      write_reg(REG_FRAME_WIDTH, 13'd0);
      write_reg(REG_FRAME_HEIGHT, 13'd0);
      for (int i = 0; i < 9; i++)
         send_req(CMD_PIXEL, (i % 2 == 0) ? 8'd255 : 8'd0);
      for (int i = 0; i < 10; i++)
         send_req(CMD_DRAIN, 8'h00);
      settle();

      // Register values above the maximum saturate to the largest frame; only
      // part of its first row is sent before the next write restarts it.
      write_reg(REG_FRAME_WIDTH, 13'h1FFF);
      write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
      steady_sender = 1'b0;
      run_frame(200, 0, 0);
      settle();

      // Random part: a stream of frames, some followed by new frame sizes.
      must_configure = 1'b1;
      while (pixels_sent < TARGET_PIXELS) begin
         if (must_configure || $urandom_range(0, 9) < 4) begin
            settle();
            r = $urandom_range(0, 3);
            if (must_configure || r != 0)
               write_reg(REG_FRAME_WIDTH, width_code());
            if (must_configure || r != 1)
               write_reg(REG_FRAME_HEIGHT, height_code());
            must_configure = 1'b0;
         end
         steady_sender = ($urandom_range(0, 4) == 0);
         total = frame_cols * frame_rows;
         owed  = (total < 3 * frame_cols + 3) ? total : 3 * frame_cols + 3;
         r     = $urandom_range(0, 99);
         if (total > 600) begin
            // Large frames are only started, then cut short by a new size.
            run_frame($urandom_range(20, 300), 0, $urandom_range(0, 3));
            must_configure = 1'b1;
         end else if (r < 80) begin
            run_frame(total, owed + $urandom_range(0, 2), $urandom_range(0, 3));
         end else if (r < 90) begin
            // Owed results left behind are dropped by the next frame's pixels.
            run_frame(total, $urandom_range(0, owed - 1), $urandom_range(0, 3));
         end else begin
            run_frame($urandom_range(1, total - 1), 0, $urandom_range(0, 3));
         end
      end

      settle();
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
